// ===== sv/rrss_pkg.sv =====
`default_nettype none
package rrss_pkg;

    localparam int DEF_MAX_TASKS = 16;

    // field widths
    localparam int CMD_W      = 2;
    localparam int ID_W       = 4;
    localparam int TIME_W     = 16;
    localparam int TCOUNT_W   = 5;
    localparam int TDIV_W     = 8;
    localparam int MASK_W     = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    // register reset values
    localparam logic [TCOUNT_W-1:0] TASK_COUNT_RST  = 5'd1;
    localparam logic [TDIV_W-1:0]   TICK_DIVIDE_RST = 8'd10;

    // configuration register indexes
    localparam logic CFG_TASK_COUNT  = 1'b0;
    localparam logic CFG_TICK_DIVIDE = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SLEEP = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

endpackage
`default_nettype wire

// ===== sv/rrss_wake_ram.sv =====
`default_nettype none
module rrss_wake_ram import rrss_pkg::*; #(
    parameter int DEPTH = DEF_MAX_TASKS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [TIME_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [TIME_W-1:0] o_rdata
);

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [TIME_W-1:0] r_rdata;
    logic              r_rvalid;

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule
`default_nettype wire

// ===== sv/rrss_picker.sv =====
`default_nettype none
module rrss_picker import rrss_pkg::*; #(
    parameter int MAX_TASKS = DEF_MAX_TASKS,
    parameter int IW        = $clog2(MAX_TASKS),
    parameter int CW        = $clog2(MAX_TASKS + 1)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [IW-1:0]        i_cur,
    input  wire logic [CW-1:0]        i_count,
    input  wire logic [MAX_TASKS-1:0] i_runnable,
    output logic                      o_done,
    output logic      [IW-1:0]        o_task
);

    logic          r_busy;
    logic [IW-1:0] r_it;
    logic [CW-1:0] r_k;
    logic [IW-1:0] nxt;
    logic [CW-1:0] last;

    // one candidate a cycle, wrapping from the last registered task to task 1
    assign last = i_count - CW'(1);
    assign nxt  = (CW'(r_it) >= last) ? IW'(1) : r_it + IW'(1);

    always_comb begin
        o_done = 1'b0;
        o_task = '0;
        if (r_busy) begin
            if (i_count < CW'(2)) begin
                o_done = 1'b1;
            end else if (i_runnable[nxt]) begin
                o_done = 1'b1;
                o_task = nxt;
            end else if (r_k + CW'(1) >= last) begin
                o_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_it   <= '0;
            r_k    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_it   <= (i_cur == '0) ? IW'(1) : i_cur;
            r_k    <= '0;
        end else if (r_busy) begin
            if (o_done) begin
                r_busy <= 1'b0;
            end else begin
                r_it <= nxt;
                r_k  <= r_k + CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== sv/round_robin_sleep_scheduler.sv =====
`default_nettype none
// channel   dir  beat fields (lowest bit up)
// s_axis    in   command[1:0] task_id[5:2] sleep_time[21:6], zero pad to 24
// m_axis    out  running_task[3:0] runnable_mask[19:4] time_now[35:20], pad to 40
// cfg       in   index 0 task_count[4:0], index 1 tick_divide[7:0]
//
// start, stop and ticks without a time step go from the beat straight to the result
// a tick with a time step walks the wake ram once
// sleep/yield walks the task list in the picker
// synchronous active-low reset: all tasks runnable, idle task running, time zero
// a new beat is taken while the last result still waits on m_axis
module round_robin_sleep_scheduler import rrss_pkg::*; #(
    parameter int MAX_TASKS = DEF_MAX_TASKS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_addr,
    input  wire logic [TDIV_W-1:0]    i_cfg_wdata,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // command, task_id, sleep_time
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic      [M_TDATA_W-1:0] m_axis_tdata   // running_task, runnable_mask, time_now
);

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WSCAN,
        ST_PICK,
        ST_DONE
    } t_state;

    // state
    t_state                 r_state, n_state;
    logic [MAX_TASKS-1:0]   r_runnable, n_runnable;
    logic [MAX_TASKS-1:0]   r_stopped, n_stopped;  // neither bit set: waiting
    logic [IW-1:0]          r_cur, n_cur;
    logic [TIME_W-1:0]      r_time, n_time;
    logic [TDIV_W-1:0]      r_phase, n_phase;
    logic [CW-1:0]          r_idx, n_idx;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]          r_cmp_idx, n_cmp_idx;
    logic                   r_m_valid, n_m_valid;
    logic [M_TDATA_W-1:0]   r_m_data, n_m_data;
    logic [TCOUNT_W-1:0]    r_task_count;
    logic [TDIV_W-1:0]      r_tick_divide;

    // input beat fields
    t_cmd                   in_cmd;
    logic [ID_W-1:0]        in_id;
    logic [TIME_W-1:0]      in_stime;
    logic                   in_acc;

    logic [CW-1:0]          n_eff;
    logic [7:0]             tc8;
    logic                   id_ok;
    logic [IW+ID_W-1:0]     id_ext;
    logic [IW-1:0]          id_idx;
    logic [TDIV_W-1:0]      phase_inc;
    logic [MAX_TASKS-1:0]   reg_mask;
    logic [MAX_TASKS+MASK_W-1:0] mask_ext;
    logic [IW+ID_W-1:0]     cur_ext;

    logic                   wr_en;
    logic                   rd_en;
    logic [TIME_W-1:0]      rd_data;
    logic                   pk_start;
    logic                   pk_done;
    logic [IW-1:0]          pk_task;

    assign in_cmd   = t_cmd'(s_axis_tdata[1:0]);
    assign in_id    = s_axis_tdata[5:2];
    assign in_stime = s_axis_tdata[21:6];
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // task count clamped to 1..MAX_TASKS
    assign tc8 = 8'(r_task_count);
    always_comb begin
        if (tc8 == 8'd0) begin
            n_eff = CW'(1);
        end else if (tc8 > 8'(MAX_TASKS)) begin
            n_eff = CW'(MAX_TASKS);
        end else begin
            n_eff = CW'(tc8);
        end
    end

    // ids beyond the task table are dropped
    assign id_ok  = (8'(in_id) < 8'(MAX_TASKS));
    assign id_ext = {{IW{1'b0}}, in_id};
    assign id_idx = id_ext[IW-1:0];

    assign phase_inc = r_phase + TDIV_W'(1);

    // only registered tasks show in the mask
    always_comb begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            reg_mask[i] = (CW'(i) < n_eff);
        end
    end
    assign mask_ext = {{MASK_W{1'b0}}, r_runnable & reg_mask};
    assign cur_ext  = {{ID_W{1'b0}}, r_cur};

    rrss_wake_ram #(
        .DEPTH (MAX_TASKS),
        .AW    (IW)
    ) u_wake_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_en),
        .i_waddr (r_cur),
        .i_wdata (r_time + in_stime),
        .i_re    (rd_en),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (rd_data)
    );

    rrss_picker #(
        .MAX_TASKS (MAX_TASKS),
        .IW        (IW),
        .CW        (CW)
    ) u_picker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (pk_start),
        .i_cur      (r_cur),
        .i_count    (n_eff),
        .i_runnable (r_runnable),
        .o_done     (pk_done),
        .o_task     (pk_task)
    );

    always_comb begin
        n_state    = r_state;
        n_runnable = r_runnable;
        n_stopped  = r_stopped;
        n_cur      = r_cur;
        n_time     = r_time;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_idx[IW-1:0];
        n_m_valid  = r_m_valid && !m_axis_tready;
        n_m_data   = r_m_data;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        pk_start   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (in_cmd)
                        CMD_SLEEP: begin
                            // nonzero sleep_time: running task waits, then round robin pick
                            if (in_stime != '0) begin
                                n_runnable[r_cur] = 1'b0;
                                n_stopped[r_cur]  = 1'b0;
                                wr_en             = 1'b1;
                            end
                            pk_start = 1'b1;
                            n_state  = ST_PICK;
                        end
                        CMD_START: begin
                            if (id_ok) begin
                                n_runnable[id_idx] = 1'b1;
                                n_stopped[id_idx]  = 1'b0;
                            end
                            n_state = ST_DONE;
                        end
                        CMD_STOP: begin
                            if (id_ok) begin
                                n_runnable[id_idx] = 1'b0;
                                n_stopped[id_idx]  = 1'b1;
                            end
                            n_state = ST_DONE;
                        end
                        default: begin
                            // tick: time step once the phase meets the divider
                            if (phase_inc == r_tick_divide) begin
                                n_phase = '0;
                                n_time  = r_time + TIME_W'(1);
                                n_idx   = '0;
                                n_state = ST_WSCAN;
                            end else begin
                                n_phase = phase_inc;
                                n_state = ST_DONE;
                            end
                        end
                    endcase
                end
            end
            ST_WSCAN: begin
                // read one wake time a cycle, compare it in the cycle after its read
                if (r_idx < n_eff) begin
                    rd_en     = 1'b1;
                    n_idx     = r_idx + CW'(1);
                    n_cmp_vld = 1'b1;
                end
                if (r_cmp_vld && rd_data == r_time && !r_stopped[r_cmp_idx]) begin
                    n_runnable[r_cmp_idx] = 1'b1;
                end
                if (!(r_idx < n_eff) && !r_cmp_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_PICK: begin
                if (pk_done) begin
                    n_cur   = pk_task;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // output register free or being drained
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {4'b0, r_time, mask_ext[MASK_W-1:0], cur_ext[ID_W-1:0]};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_runnable    <= '1;
            r_stopped     <= '0;
            r_cur         <= '0;
            r_time        <= '0;
            r_phase       <= '0;
            r_idx         <= '0;
            r_cmp_vld     <= 1'b0;
            r_m_valid     <= 1'b0;
            r_task_count  <= TASK_COUNT_RST;
            r_tick_divide <= TICK_DIVIDE_RST;
        end else begin
            r_state    <= n_state;
            r_runnable <= n_runnable;
            r_stopped  <= n_stopped;
            r_cur      <= n_cur;
            r_time     <= n_time;
            r_phase    <= n_phase;
            r_idx      <= n_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_m_valid  <= n_m_valid;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_TASK_COUNT:  r_task_count  <= i_cfg_wdata[TCOUNT_W-1:0];
                    CFG_TICK_DIVIDE: r_tick_divide <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_m_data  <= n_m_data;
    end

`ifndef SYNTHESIS
    // picker only answers while the sequencer waits on it
    a_pick_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pk_done |-> r_state == ST_PICK)
        else $error("picker done outside pick");

    // only a tick moves the kernel time
    a_time_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_cmd != CMD_TICK) |=> $stable(r_time))
        else $error("kernel time moved without tick");

    // wake scan index never runs past the task count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WSCAN |-> r_idx <= n_eff)
        else $error("wake scan overran");
`endif

endmodule
`default_nettype wire
